>>> design/aapb_pkg.sv
// Package for the additive alpha pixel blend: pixel types, stage payloads,
// blend mode codes and configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aapb_pkg;

  localparam int unsigned PixW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumByte = PixW / ByteW;
  localparam int unsigned ScaleW  = ByteW + 1;  // opacity + (opacity >> 7), up to 256
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  // Index of the alpha byte within a pixel
  localparam int unsigned AlphaIdx = NumByte - 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDX_MODE    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_IDX_OPACITY = CfgIdxW'(1);

  localparam logic [ByteW-1:0] OPACITY_RESET = 8'hff;
  localparam logic [ByteW-1:0] BYTE_MAX      = 8'hff;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_KEEP    = 2'd1,
    MODE_OPACITY = 2'd2
  } blend_mode_e;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [NumByte-1:0] pix_bytes_t;

  // Decoded blend controls, shared by the scale and mix stages
  typedef struct packed {
    logic               scale_en;    // scale source bytes by opacity
    logic               keep_alpha;  // pass destination alpha through
    logic [ScaleW-1:0]  scale;       // opacity + (opacity >> 7)
  } blend_ctrl_t;

  // Accepted input pixel pair
  typedef struct packed {
    pix_bytes_t dest;
    pix_bytes_t src;
    logic       last;
  } pix_in_t;

  // After opacity scaling of the source
  typedef struct packed {
    pix_bytes_t dest;
    pix_bytes_t src;
    logic       last;
  } scaled_t;

  // After attenuation products (d * a) >> 8
  typedef struct packed {
    pix_bytes_t dest;
    pix_bytes_t src;
    pix_bytes_t atten;
    logic       last;
  } atten_t;

  // Final blended pixel
  typedef struct packed {
    pix_bytes_t pix;
    logic       last;
  } pix_out_t;

endpackage

`default_nettype wire

>>> design/aapb_pix_in_if.sv
// Input pixel channel: destination pixel, source pixel and span-end flag.
// Depends on aapb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface aapb_pix_in_if
  import aapb_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] dest_pixel;
  logic [PixW-1:0] src_pixel;
  logic            last_pixel;

  modport source (output valid, output dest_pixel, output src_pixel, output last_pixel,
                  input ready);
  modport sink   (input valid, input dest_pixel, input src_pixel, input last_pixel,
                  output ready);
endinterface

`default_nettype wire

>>> design/aapb_pix_out_if.sv
// Output pixel channel: blended pixel and span-end flag.
// Depends on aapb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface aapb_pix_out_if
  import aapb_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] blended_pixel;
  logic            last_out;

  modport source (output valid, output blended_pixel, output last_out, input ready);
  modport sink   (input valid, input blended_pixel, input last_out, output ready);
endinterface

`default_nettype wire

>>> design/aapb_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on aapb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface aapb_cfg_if
  import aapb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/aapb_scale.sv
// Stage 1: scales each source byte by the global opacity when enabled.
// Depends on aapb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapb_scale
  import aapb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blend_ctrl_t ctrl_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire pix_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output scaled_t          out_data_o
);

  logic    valid_q;
  scaled_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // Per-byte 8x9 multiply, keep product bits [15:8] (product >> 8)
  always_comb begin
    logic [ByteW+ScaleW-1:0] prod;
    data_d.dest = in_data_i.dest;
    data_d.last = in_data_i.last;
    for (int k = 0; k < NumByte; k++) begin
      prod = (ByteW+ScaleW)'(in_data_i.src[k]) * (ByteW+ScaleW)'(ctrl_i.scale);
      data_d.src[k] = ctrl_i.scale_en ? prod[ByteW +: ByteW] : in_data_i.src[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> design/aapb_atten.sv
// Stage 2: attenuation products (d * a) >> 8 for each destination byte.
// Depends on aapb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapb_atten
  import aapb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire scaled_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output atten_t       out_data_o
);

  logic   valid_q;
  atten_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // 8x8 multiply against the (possibly scaled) source alpha
  always_comb begin
    logic [2*ByteW-1:0] prod;
    data_d.dest = in_data_i.dest;
    data_d.src  = in_data_i.src;
    data_d.last = in_data_i.last;
    for (int k = 0; k < NumByte; k++) begin
      prod = (2*ByteW)'(in_data_i.dest[k]) * (2*ByteW)'(in_data_i.src[AlphaIdx]);
      data_d.atten[k] = prod[ByteW +: ByteW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> design/aapb_mix.sv
// Stage 3: d - atten + s with saturation at 255; optional alpha keep.
// Holds the output register. Depends on aapb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapb_mix
  import aapb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blend_ctrl_t ctrl_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire atten_t      in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pix_out_t         out_data_o
);

  logic     valid_q;
  pix_out_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // atten <= d, so the difference never wraps; one carry bit for the add
  always_comb begin
    logic [ByteW:0] sum;
    data_d.last = in_data_i.last;
    for (int k = 0; k < NumByte; k++) begin
      sum = (ByteW+1)'(in_data_i.dest[k] - in_data_i.atten[k])
          + (ByteW+1)'(in_data_i.src[k]);
      data_d.pix[k] = sum[ByteW] ? BYTE_MAX : sum[ByteW-1:0];
    end
    if (ctrl_i.keep_alpha) begin
      data_d.pix[AlphaIdx] = in_data_i.dest[AlphaIdx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> design/additive_alpha_pixel_blend.sv
// Channel    | Dir | Payload
// pix_in     | in  | dest_pixel[31:0], src_pixel[31:0], last_pixel
// pix_out    | out | blended_pixel[31:0], last_out
// cfg_wr     | in  | index[7:0], data[31:0]  (0: blend_mode, 1: opacity)
//
// One pixel per clock sustained while pix_out is ready; three register stages
// (opacity scale, attenuation multiply, add/saturate). An input transfer is
// registered by each stage in that order before output valid rises.
// Reset clears the stage valid bits and sets blend_mode 0, opacity 255.
// A stalled output holds its pixel; stages behind it fill their bubbles and
// then stall in turn, so nothing is dropped or repeated. Config writes are
// always taken; unknown indexes are ignored. Depends on aapb_pkg and the
// aapb interfaces.
`timescale 1ns / 1ps
`default_nettype none

module additive_alpha_pixel_blend
  import aapb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  aapb_pix_in_if.sink   pix_in,
  aapb_pix_out_if.source pix_out,
  aapb_cfg_if.sink      cfg_wr
);

  blend_mode_e mode_q;
  logic [ByteW-1:0] opacity_q;
  blend_ctrl_t ctrl;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_PLAIN;
      opacity_q <= OPACITY_RESET;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.index == CFG_IDX_MODE) begin
        mode_q <= blend_mode_e'(cfg_wr.data[1:0]);
      end
      if (cfg_wr.index == CFG_IDX_OPACITY) begin
        opacity_q <= cfg_wr.data[ByteW-1:0];
      end
    end
  end

  // Decode; the unused mode code blends as plain
  always_comb begin
    ctrl.scale_en   = (mode_q == MODE_OPACITY);
    ctrl.keep_alpha = (mode_q == MODE_KEEP);
    ctrl.scale      = ScaleW'(opacity_q) + ScaleW'(opacity_q[ByteW-1]);
  end

  pix_in_t  in_data;
  scaled_t  s1_data;
  atten_t   s2_data;
  pix_out_t s3_data;
  logic     s1_valid, s1_ready, s2_valid, s2_ready;

  always_comb begin
    for (int k = 0; k < NumByte; k++) begin
      in_data.dest[k] = pix_in.dest_pixel[k*ByteW +: ByteW];
      in_data.src[k]  = pix_in.src_pixel[k*ByteW +: ByteW];
    end
    in_data.last = pix_in.last_pixel;
  end

  aapb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .in_data_i   (in_data),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_data_o  (s1_data)
  );

  aapb_atten u_atten (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s2_data)
  );

  aapb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (s2_data),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .out_data_o  (s3_data)
  );

  assign pix_out.blended_pixel = s3_data.pix;
  assign pix_out.last_out      = s3_data.last;

endmodule

`default_nettype wire
